[design/red_pkg.sv]
// Package for the repeated event escalation detector.
// Holds register indexes, reset values, reaction codes and shared widths.
// No dependencies.
`default_nettype none

package red_pkg;

    localparam int TIME_W = 32;
    localparam int YAW_W  = 16;
    localparam int CNT_W  = 9;     // holds any fill count up to 256
    localparam int OCNT_W = 5;     // count fields on the result channel
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DEF_HISTORY_DEPTH   = 16;
    localparam int DEF_DETECTION_DEPTH = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [1:0]           reaction_t;

    localparam cfg_idx_t CFG_CHECKS_ENABLED       = 3'd0;
    localparam cfg_idx_t CFG_ACTIVATION_WINDOW_MS = 3'd1;
    localparam cfg_idx_t CFG_YAW_WINDOW           = 3'd2;
    localparam cfg_idx_t CFG_ACTIVATIONS_ALLOWED  = 3'd3;
    localparam cfg_idx_t CFG_DETECTION_WINDOW_MS  = 3'd4;
    localparam cfg_idx_t CFG_DETECTIONS_ALLOWED   = 3'd5;
    localparam cfg_idx_t CFG_ALWAYS_LOCK_TREADS   = 3'd6;

    localparam logic [TIME_W-1:0] RST_ACTIVATION_WINDOW_MS = 32'd10000;
    localparam logic [YAW_W-1:0]  RST_YAW_WINDOW           = 16'd4096;
    localparam logic [3:0]        RST_ACTIVATIONS_ALLOWED  = 4'd3;
    localparam logic [TIME_W-1:0] RST_DETECTION_WINDOW_MS  = 32'd60000;
    localparam logic [3:0]        RST_DETECTIONS_ALLOWED   = 4'd2;

    localparam reaction_t REACT_ANIMATION = 2'd0;
    localparam reaction_t REACT_RETREAT   = 2'd1;
    localparam reaction_t REACT_HELP      = 2'd2;

endpackage

`default_nettype wire

[design/red_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered. Depends on red_pkg for defaults.
`default_nettype none

module red_ram #(
    parameter int WIDTH = red_pkg::TIME_W,
    parameter int DEPTH = red_pkg::DEF_HISTORY_DEPTH
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[design/repeated_event_escalation_detector.sv]
// Top level of the repeated event escalation detector: sequencer, ring
// pointers and result register around two history RAMs.
// Depends on red_pkg and red_ram.
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+---------------------
//  input    | s_event_time_ms, s_yaw_angle, s_from_back | s_valid / s_ready
//  result   | m_reaction, m_lock_treads, m_*_count   | m_valid / m_ready
//  config   | cfg_index, cfg_wdata                   | cfg_wr_en, no wait
//
// One item at a time: IDLE, ACT_PRUNE until no stale activation record is left,
// ACT_APPEND, then on escalation DET_UPDATE likewise for detections, RESULT.
// Popping reads the oldest record of a ring, one RAM read per cycle.
// An item is taken while an earlier result still waits in the output register;
// the sequencer stalls only in its last step if that register is still full.
// Reset clears pointers, fills, m_valid and config; no clearing pass is needed.
`default_nettype none

module repeated_event_escalation_detector #(
    parameter int HISTORY_DEPTH   = red_pkg::DEF_HISTORY_DEPTH,
    parameter int DETECTION_DEPTH = red_pkg::DEF_DETECTION_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [red_pkg::TIME_W-1:0]        s_event_time_ms,
    input  wire logic signed [red_pkg::YAW_W-1:0]  s_yaw_angle,
    input  wire logic                              s_from_back,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [1:0]                        m_reaction,
    output logic                                   m_lock_treads,
    output logic      [red_pkg::OCNT_W-1:0]        m_activation_count,
    output logic      [red_pkg::OCNT_W-1:0]        m_detection_count,
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [red_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [red_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    import red_pkg::*;

    localparam int AHW = $clog2(HISTORY_DEPTH);
    localparam int AFW = $clog2(HISTORY_DEPTH + 1);
    localparam int ASW = AHW + 1;
    localparam int DHW = $clog2(DETECTION_DEPTH);
    localparam int DFW = $clog2(DETECTION_DEPTH + 1);
    localparam int DSW = DHW + 1;
    localparam int ACT_W = TIME_W + YAW_W;

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_ACT_PRUNE  = 3'd1;
    localparam logic [2:0] ST_ACT_APPEND = 3'd2;
    localparam logic [2:0] ST_DET_UPDATE = 3'd3;
    localparam logic [2:0] ST_RESULT     = 3'd4;

    // configuration registers
    logic              checks_enabled_reg;
    logic [TIME_W-1:0] act_window_reg;
    logic [YAW_W-1:0]  yaw_window_reg;
    logic [3:0]        act_allowed_reg;
    logic [TIME_W-1:0] det_window_reg;
    logic [3:0]        det_allowed_reg;
    logic              always_lock_reg;

    // control state
    logic [2:0]   state_reg,    state_next;
    logic [AHW-1:0] act_head_reg, act_head_next;
    logic [AFW-1:0] act_fill_reg, act_fill_next;
    logic [DHW-1:0] det_head_reg, det_head_next;
    logic [DFW-1:0] det_fill_reg, det_fill_next;
    logic         m_valid_reg,  m_valid_next;

    // payload
    logic [TIME_W-1:0] now_reg;
    logic [YAW_W-1:0]  yaw_reg;
    logic              back_reg;
    logic [TIME_W-1:0] det_last_reg, det_last_next;
    logic              det_last_load;
    reaction_t         res_reaction_reg, res_reaction_next;
    logic              res_lock_reg,     res_lock_next;
    logic [OCNT_W-1:0] res_act_cnt_reg,  res_act_cnt_next;
    logic [OCNT_W-1:0] res_det_cnt_reg,  res_det_cnt_next;
    logic              res_load;
    logic              m_load;
    reaction_t         m_reaction_reg;
    logic              m_lock_reg;
    logic [OCNT_W-1:0] m_act_cnt_reg;
    logic [OCNT_W-1:0] m_det_cnt_reg;

    // RAM ports
    logic             act_we;
    logic [AHW-1:0]   act_waddr;
    logic [ACT_W-1:0] act_rdata;
    logic             det_we;
    logic [DHW-1:0]   det_waddr;
    logic [TIME_W-1:0] det_rdata;

    // datapath
    logic [TIME_W-1:0] act_rtime;
    logic [YAW_W-1:0]  act_ryaw;
    logic [TIME_W-1:0] act_age;
    logic              act_stale;
    logic [YAW_W-1:0]  yaw_diff;
    logic [YAW_W:0]    yaw_mag;
    logic              yaw_far;
    logic [AHW-1:0]    act_head_inc;
    logic [ASW-1:0]    act_sum;
    logic [AFW-1:0]    act_fill_inc;
    logic              act_full;
    logic              act_escalate;
    logic [TIME_W-1:0] det_age;
    logic              det_stale;
    logic              det_dup;
    logic              det_full;
    logic [DHW-1:0]    det_head_inc;
    logic [DSW-1:0]    det_sum;
    logic [DHW-1:0]    det_slot;
    logic [DFW-1:0]    det_fill_new;

    red_ram #(
        .WIDTH (ACT_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_act_ram (
        .aclk    (aclk),
        .wr_en   (act_we),
        .wr_addr (act_waddr),
        .wr_data ({now_reg, yaw_reg}),
        .rd_addr (act_head_next),
        .rd_data (act_rdata)
    );

    red_ram #(
        .WIDTH (TIME_W),
        .DEPTH (DETECTION_DEPTH)
    ) u_det_ram (
        .aclk    (aclk),
        .wr_en   (det_we),
        .wr_addr (det_waddr),
        .wr_data (now_reg),
        .rd_addr (det_head_next),
        .rd_data (det_rdata)
    );

    // ---- activation ring datapath ----
    assign act_rtime = act_rdata[ACT_W-1:YAW_W];
    assign act_ryaw  = act_rdata[YAW_W-1:0];
    assign act_age   = now_reg - act_rtime;
    assign act_stale = (act_fill_reg != '0) && (act_age > act_window_reg);
    assign yaw_diff  = yaw_reg - act_ryaw;
    assign yaw_mag   = yaw_diff[YAW_W-1] ? ((YAW_W+1)'(1) << YAW_W) - {1'b0, yaw_diff}
                                         : {1'b0, yaw_diff};
    assign yaw_far   = (act_fill_reg != '0) && (yaw_mag > {1'b0, yaw_window_reg});
    assign act_head_inc = (act_head_reg == AHW'(HISTORY_DEPTH - 1)) ? '0 : act_head_reg + 1'b1;
    assign act_full  = (act_fill_reg == AFW'(HISTORY_DEPTH));
    assign act_sum   = ASW'(act_head_reg) + ASW'(act_fill_reg);
    assign act_waddr = (act_sum >= ASW'(HISTORY_DEPTH)) ? AHW'(act_sum - ASW'(HISTORY_DEPTH))
                                                        : AHW'(act_sum);
    assign act_fill_inc = act_fill_reg + 1'b1;
    assign act_escalate = checks_enabled_reg &&
                          (CNT_W'(act_fill_inc) > CNT_W'(act_allowed_reg));

    // ---- detection ring datapath ----
    assign det_age   = now_reg - det_rdata;
    assign det_stale = (det_fill_reg != '0) && (det_age > det_window_reg);
    // newest record is always the last one appended, kept in a register
    assign det_dup   = (det_fill_reg != '0) && (det_last_reg == now_reg);
    assign det_full  = (det_fill_reg == DFW'(DETECTION_DEPTH));
    assign det_head_inc = (det_head_reg == DHW'(DETECTION_DEPTH - 1)) ? '0 : det_head_reg + 1'b1;
    assign det_sum   = DSW'(det_head_reg) + DSW'(det_fill_reg);
    // a full ring overwrites its oldest slot, which is the head
    assign det_slot  = det_full ? det_head_reg :
                       (det_sum >= DSW'(DETECTION_DEPTH)) ? DHW'(det_sum - DSW'(DETECTION_DEPTH))
                                                          : DHW'(det_sum);
    assign det_waddr = det_slot;
    assign det_fill_new = det_dup ? det_fill_reg :
                          det_full ? det_fill_reg : det_fill_reg + 1'b1;

    // ---- sequencer ----
    always_comb begin
        state_next        = state_reg;
        act_head_next     = act_head_reg;
        act_fill_next     = act_fill_reg;
        det_head_next     = det_head_reg;
        det_fill_next     = det_fill_reg;
        det_last_next     = det_last_reg;
        det_last_load     = 1'b0;
        m_valid_next      = m_valid_reg;
        m_load            = 1'b0;
        res_load          = 1'b0;
        res_reaction_next = res_reaction_reg;
        res_lock_next     = res_lock_reg;
        res_act_cnt_next  = res_act_cnt_reg;
        res_det_cnt_next  = res_det_cnt_reg;
        act_we            = 1'b0;
        det_we            = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_ACT_PRUNE;
                end
            end
            ST_ACT_PRUNE: begin
                if (act_stale) begin
                    // drop the oldest record and read the next one
                    act_head_next = act_head_inc;
                    act_fill_next = act_fill_reg - 1'b1;
                end else begin
                    if (yaw_far) begin
                        act_head_next = '0;
                        act_fill_next = '0;
                    end else if (act_full) begin
                        act_head_next = act_head_inc;
                        act_fill_next = AFW'(HISTORY_DEPTH - 1);
                    end
                    state_next = ST_ACT_APPEND;
                end
            end
            ST_ACT_APPEND: begin
                act_we   = 1'b1;
                res_load = 1'b1;
                if (act_escalate) begin
                    act_head_next = '0;
                    act_fill_next = '0;
                    state_next    = ST_DET_UPDATE;
                end else begin
                    act_fill_next     = act_fill_inc;
                    res_reaction_next = REACT_ANIMATION;
                    res_lock_next     = always_lock_reg | back_reg;
                    res_act_cnt_next  = OCNT_W'(act_fill_inc);
                    res_det_cnt_next  = OCNT_W'(det_fill_reg);
                    state_next        = ST_RESULT;
                end
            end
            ST_DET_UPDATE: begin
                if (det_stale) begin
                    det_head_next = det_head_inc;
                    det_fill_next = det_fill_reg - 1'b1;
                end else begin
                    if (!det_dup) begin
                        det_we        = 1'b1;
                        det_last_load = 1'b1;
                        det_last_next = now_reg;
                        det_fill_next = det_fill_new;
                        if (det_full) begin
                            det_head_next = det_head_inc;
                        end
                    end
                    res_load          = 1'b1;
                    res_reaction_next = (CNT_W'(det_fill_new) > CNT_W'(det_allowed_reg))
                                        ? REACT_HELP : REACT_RETREAT;
                    res_lock_next     = 1'b0;
                    res_act_cnt_next  = '0;
                    res_det_cnt_next  = OCNT_W'(det_fill_new);
                    state_next        = ST_RESULT;
                end
            end
            ST_RESULT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_load       = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            act_head_reg <= '0;
            act_fill_reg <= '0;
            det_head_reg <= '0;
            det_fill_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            act_head_reg <= act_head_next;
            act_fill_reg <= act_fill_next;
            det_head_reg <= det_head_next;
            det_fill_reg <= det_fill_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg  <= s_event_time_ms;
            yaw_reg  <= s_yaw_angle;
            back_reg <= s_from_back;
        end
        if (det_last_load) begin
            det_last_reg <= det_last_next;
        end
        if (res_load) begin
            res_reaction_reg <= res_reaction_next;
            res_lock_reg     <= res_lock_next;
            res_act_cnt_reg  <= res_act_cnt_next;
            res_det_cnt_reg  <= res_det_cnt_next;
        end
        if (m_load) begin
            m_reaction_reg <= res_reaction_reg;
            m_lock_reg     <= res_lock_reg;
            m_act_cnt_reg  <= res_act_cnt_reg;
            m_det_cnt_reg  <= res_det_cnt_reg;
        end
    end

    // ---- configuration registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            checks_enabled_reg <= 1'b0;
            act_window_reg     <= RST_ACTIVATION_WINDOW_MS;
            yaw_window_reg     <= RST_YAW_WINDOW;
            act_allowed_reg    <= RST_ACTIVATIONS_ALLOWED;
            det_window_reg     <= RST_DETECTION_WINDOW_MS;
            det_allowed_reg    <= RST_DETECTIONS_ALLOWED;
            always_lock_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CHECKS_ENABLED:       checks_enabled_reg <= cfg_wdata[0];
                CFG_ACTIVATION_WINDOW_MS: act_window_reg     <= cfg_wdata[TIME_W-1:0];
                CFG_YAW_WINDOW:           yaw_window_reg     <= cfg_wdata[YAW_W-1:0];
                CFG_ACTIVATIONS_ALLOWED:  act_allowed_reg    <= cfg_wdata[3:0];
                CFG_DETECTION_WINDOW_MS:  det_window_reg     <= cfg_wdata[TIME_W-1:0];
                CFG_DETECTIONS_ALLOWED:   det_allowed_reg    <= cfg_wdata[3:0];
                CFG_ALWAYS_LOCK_TREADS:   always_lock_reg    <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_reaction         = m_reaction_reg;
    assign m_lock_treads      = m_lock_reg;
    assign m_activation_count = m_act_cnt_reg;
    assign m_detection_count  = m_det_cnt_reg;

endmodule

`default_nettype wire
